### design/flv_vtp_pkg.sv
// Types and constants for the FLV video tag header parser.
package flv_vtp_pkg;

    localparam int DATA_W   = 8;
    localparam int TDATA_W  = 112;
    localparam int TUSER_W  = 3;
    localparam int CT_W     = 24;
    localparam int CNT_OUT_W = 24;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_AVC    = 6'b000010,
        PH_FOURCC = 6'b000100,
        PH_CT     = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_IGNORE = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        CLS_HEADER  = 3'd0,
        CLS_AVC     = 3'd1,
        CLS_FOURCC  = 3'd2,
        CLS_CT      = 3'd3,
        CLS_PAYLOAD = 3'd4,
        CLS_IGNORED = 3'd5
    } byte_class_t;

    localparam logic [3:0] PKT_SEQ_START = 4'd0;
    localparam logic [3:0] PKT_CODED     = 4'd1;
    localparam logic [3:0] PKT_SEQ_END   = 4'd2;
    localparam logic [3:0] PKT_CODED_X   = 4'd3;
    localparam logic [3:0] PKT_METADATA  = 4'd4;

    localparam logic [1:0] REG_AVC_CODEC_ID = 2'd0;
    localparam logic [1:0] REG_HEVC_FOURCC  = 2'd1;
    localparam logic [1:0] REG_AV1_FOURCC   = 2'd2;

    localparam logic [3:0]  AVC_CODEC_RESET   = 4'd7;
    localparam logic [31:0] HEVC_FOURCC_RESET = 32'h6876_6331;
    localparam logic [31:0] AV1_FOURCC_RESET  = 32'h6176_3031;

    localparam logic [1:0] LAST_AVC_IDX    = 2'd3;
    localparam logic [1:0] LAST_FOURCC_IDX = 2'd3;
    localparam logic [1:0] LAST_CT_IDX     = 2'd2;

endpackage

### design/flv_video_tag_header_parser.sv
// Top level of the FLV video tag header parser, one tag byte per transfer.
//
//  channel | direction | handshake              | contents
//  s_*     | in        | s_tvalid / s_tready    | tdata: data_byte; tuser: start_of_tag
//  m_*     | out       | m_tvalid / m_tready    | tdata: header fields; tuser: byte_class
//  apb     | in        | psel & penable & pwrite | avc_codec_id, hevc_fourcc, av1_fourcc
//
// One byte per cycle while s_tready is high: the parse state and the result
// register load in the cycle a byte transfers; results show the next cycle.
// s_tready stays high while the result register is empty or being drained.
// rst_n clears the parse state, the result valid and the registers to their
// defaults; a stalled result holds until m_tready.
module flv_video_tag_header_parser
    import flv_vtp_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]          s_tuser,   // [0] start_of_tag
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] payload_byte, [8] is_extended, [12:9] codec_id, [15:13] frame_kind,
    // [19:16] packet_kind, [51:20] fourcc_value, [59:52] avc_packet_kind,
    // [83:60] composition_time, [84] header_done, [108:85] payload_count
    output logic [TDATA_W-1:0]  m_tdata,
    output logic [TUSER_W-1:0]  m_tuser,   // [2:0] byte_class
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CNT_EXT_W = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

    logic [3:0]             avc_codec_reg;
    logic [31:0]            hevc_fourcc_reg;
    logic [31:0]            av1_fourcc_reg;

    phase_t                 phase_reg, phase_next, cur_phase;
    logic [1:0]             idx_reg, idx_next, cur_idx;
    logic                   ext_reg, ext_next, cur_ext;
    logic [3:0]             codec_reg, codec_next, cur_codec;
    logic [2:0]             frame_reg, frame_next, cur_frame;
    logic [3:0]             pkt_reg, pkt_next, cur_pkt;
    logic [31:0]            fourcc_reg, fourcc_next, cur_fourcc;
    logic [31:0]            extra_reg, extra_next, cur_extra;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, cur_count;

    logic                   m_valid_reg;
    logic [TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [TUSER_W-1:0]     m_tuser_reg;

    byte_class_t            cls;
    logic [7:0]             b;
    logic [7:0]             pbyte;
    logic                   done;
    logic [7:0]             avck;
    logic [CT_W-1:0]        ct;
    logic [CNT_EXT_W-1:0]   cnt_ext;
    logic [CNT_OUT_W-1:0]   cnt;
    logic                   s_xfer;
    logic                   cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = ~m_valid_reg | m_tready;
    assign s_xfer   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign b        = s_tdata;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_AVC_CODEC_ID: prdata = {28'd0, avc_codec_reg};
            REG_HEVC_FOURCC:  prdata = hevc_fourcc_reg;
            REG_AV1_FOURCC:   prdata = av1_fourcc_reg;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avc_codec_reg   <= AVC_CODEC_RESET;
            hevc_fourcc_reg <= HEVC_FOURCC_RESET;
            av1_fourcc_reg  <= AV1_FOURCC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_AVC_CODEC_ID: avc_codec_reg   <= pwdata[3:0];
                REG_HEVC_FOURCC:  hevc_fourcc_reg <= pwdata;
                REG_AV1_FOURCC:   av1_fourcc_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    // Start of tag: restart from a cleared state.
    always_comb
    begin
        if (s_tuser[0])
        begin
            cur_phase  = PH_HEADER;
            cur_idx    = '0;
            cur_ext    = 1'b0;
            cur_codec  = '0;
            cur_frame  = '0;
            cur_pkt    = '0;
            cur_fourcc = '0;
            cur_extra  = '0;
            cur_count  = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_idx    = idx_reg;
            cur_ext    = ext_reg;
            cur_codec  = codec_reg;
            cur_frame  = frame_reg;
            cur_pkt    = pkt_reg;
            cur_fourcc = fourcc_reg;
            cur_extra  = extra_reg;
            cur_count  = count_reg;
        end
    end

    always_comb
    begin
        phase_next  = cur_phase;
        idx_next    = cur_idx;
        ext_next    = cur_ext;
        codec_next  = cur_codec;
        frame_next  = cur_frame;
        pkt_next    = cur_pkt;
        fourcc_next = cur_fourcc;
        extra_next  = cur_extra;
        count_next  = cur_count;
        cls         = CLS_IGNORED;
        pbyte       = 8'd0;
        done        = 1'b0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                cls        = CLS_HEADER;
                ext_next   = b[7];
                frame_next = b[6:4];
                idx_next   = '0;
                if (!b[7])
                begin
                    codec_next = b[3:0];
                    if (b[3:0] == avc_codec_reg)
                    begin
                        phase_next = PH_AVC;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    pkt_next   = b[3:0];
                    phase_next = PH_FOURCC;
                end
            end
            PH_AVC:
            begin
                cls = CLS_AVC;
                unique case (cur_idx)
                    2'd0:    extra_next[31:24] = b;
                    2'd1:    extra_next[23:16] = b;
                    2'd2:    extra_next[15:8]  = b;
                    default: extra_next[7:0]   = b;
                endcase
                if (cur_idx == LAST_AVC_IDX)
                begin
                    phase_next = PH_DATA;
                    idx_next   = '0;
                    done       = 1'b1;
                end
                else
                begin
                    idx_next = cur_idx + 2'd1;
                end
            end
            PH_FOURCC:
            begin
                cls = CLS_FOURCC;
                unique case (cur_idx)
                    2'd0:    fourcc_next[31:24] = b;
                    2'd1:    fourcc_next[23:16] = b;
                    2'd2:    fourcc_next[15:8]  = b;
                    default: fourcc_next[7:0]   = b;
                endcase
                if (cur_idx == LAST_FOURCC_IDX)
                begin
                    idx_next = '0;
                    done     = 1'b1;
                    if (cur_pkt == PKT_METADATA)
                    begin
                        frame_next = '0;
                        phase_next = PH_IGNORE;
                    end
                    else if (cur_pkt == PKT_SEQ_END)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else if (fourcc_next == hevc_fourcc_reg)
                    begin
                        if (cur_pkt == PKT_SEQ_START || cur_pkt == PKT_CODED_X)
                        begin
                            phase_next = PH_DATA;
                        end
                        else if (cur_pkt == PKT_CODED)
                        begin
                            phase_next = PH_CT;
                            done       = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (fourcc_next == av1_fourcc_reg)
                    begin
                        if (cur_pkt == PKT_SEQ_START || cur_pkt == PKT_CODED)
                            phase_next = PH_DATA;
                        else
                            phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                else
                begin
                    idx_next = cur_idx + 2'd1;
                end
            end
            PH_CT:
            begin
                cls = CLS_CT;
                unique case (cur_idx)
                    2'd0:    extra_next[31:24] = b;
                    2'd1:    extra_next[23:16] = b;
                    2'd2:    extra_next[15:8]  = b;
                    default: extra_next[7:0]   = b;
                endcase
                if (cur_idx >= LAST_CT_IDX)
                begin
                    phase_next = PH_DATA;
                    idx_next   = '0;
                    done       = 1'b1;
                end
                else
                begin
                    idx_next = cur_idx + 2'd1;
                end
            end
            PH_DATA:
            begin
                cls   = CLS_PAYLOAD;
                pbyte = b;
                if (cur_count != {COUNT_WIDTH{1'b1}})
                    count_next = cur_count + COUNT_WIDTH'(1);
            end
            default:
            begin
                cls = CLS_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        avck = 8'd0;
        ct   = '0;
        if (!ext_next && codec_next == avc_codec_reg)
        begin
            avck = extra_next[31:24];
            ct   = extra_next[23:0];
        end
        else if (ext_next && fourcc_next == hevc_fourcc_reg && pkt_next == PKT_CODED)
        begin
            ct = extra_next[31:8];
        end
        cnt_ext = CNT_EXT_W'(count_next);
        if (cnt_ext > CNT_EXT_W'({CNT_OUT_W{1'b1}}))
            cnt = {CNT_OUT_W{1'b1}};
        else
            cnt = cnt_ext[CNT_OUT_W-1:0];
        m_tdata_next = {3'd0, cnt, done, ct, avck, fourcc_next, pkt_next,
                        frame_next, codec_next, ext_next, pbyte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            idx_reg    <= '0;
            ext_reg    <= 1'b0;
            codec_reg  <= '0;
            frame_reg  <= '0;
            pkt_reg    <= '0;
            fourcc_reg <= '0;
            extra_reg  <= '0;
            count_reg  <= '0;
        end
        else if (s_xfer)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            ext_reg    <= ext_next;
            codec_reg  <= codec_next;
            frame_reg  <= frame_next;
            pkt_reg    <= pkt_next;
            fourcc_reg <= fourcc_next;
            extra_reg  <= extra_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_xfer)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // Load the result on every input transfer.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= cls;
        end
    end

endmodule
